/* rtl/stod_pkg.sv */
// Shared types and constants for the score to digit sprites block.
// No dependencies; imported by stod_bcd_conv and score_to_digit_sprites.
package stod_pkg;

    // Action codes carried in the input word; code 3 has no meaning
    typedef enum logic [1:0] {
        ACT_SET  = 2'd0,
        ACT_ADD  = 2'd1,
        ACT_DRAW = 2'd2
    } action_t;

    // Register indexes on the configuration port
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 8;
    localparam logic [CFG_IDX_W-1:0] REG_X_ORIGIN   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_Y_ORIGIN   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FIRST_TILE = 2'd2;

    localparam int DIGIT_W  = 4;
    localparam int COORD_W  = 8;
    localparam int X_STEP   = 8;
    localparam int IN_W     = 16;

endpackage

/* rtl/stod_bcd_conv.sv */
// Iterative binary to BCD converter (shift and add-3), one bit per cycle.
// Depends on stod_pkg for the digit width.
module stod_bcd_conv
    import stod_pkg::*;
#(
    parameter int VALUE_BITS = 16,
    parameter int DIGITS     = 5
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [VALUE_BITS-1:0]       value,
    output logic                        done,
    output logic [DIGITS*DIGIT_W-1:0]   bcd
);

    localparam int CNT_W = $clog2(VALUE_BITS + 1);
    localparam int BCD_W = DIGITS * DIGIT_W;

    logic [VALUE_BITS-1:0] val_reg;
    logic [BCD_W-1:0]      bcd_reg;
    logic [BCD_W-1:0]      bcd_adj;
    logic [CNT_W-1:0]      cnt_reg;
    logic                  busy_reg;
    logic                  done_reg;

    // Correct every digit of 5 or more before the shift
    always_comb begin
        for (int i = 0; i < DIGITS; i++) begin
            if (bcd_reg[i*DIGIT_W +: DIGIT_W] >= DIGIT_W'(5)) begin
                bcd_adj[i*DIGIT_W +: DIGIT_W] = bcd_reg[i*DIGIT_W +: DIGIT_W] + DIGIT_W'(3);
            end else begin
                bcd_adj[i*DIGIT_W +: DIGIT_W] = bcd_reg[i*DIGIT_W +: DIGIT_W];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(VALUE_BITS);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
        if (start) begin
            val_reg <= value;
            bcd_reg <= '0;
        end else if (busy_reg) begin
            val_reg <= {val_reg[VALUE_BITS-2:0], 1'b0};
            bcd_reg <= {bcd_adj[BCD_W-2:0], val_reg[VALUE_BITS-1]};
        end
    end

    assign done = done_reg;
    assign bcd  = bcd_reg;

endmodule

/* rtl/score_to_digit_sprites.sv */
// Top level: score register, configuration registers, draw sequencer and output word.
// Depends on stod_pkg and stod_bcd_conv.
//
// Use: each input word carries an action. Set loads the score, add adds a signed
// delta (wrapping); neither gives any output. Draw converts the
// score to decimal and sends one sprite word per digit, leftmost first, leading
// zeros dropped (zero gives a single digit), m_tlast on the final sprite.
// Configuration (x origin, y origin, first tile) is written through cfg_we,
// cfg_addr and cfg_wdata, and the user must write it only while the block is
// idle; the block itself does not enforce this. It is read at each draw.
// A draw is accepted, passes through the bit-serial BCD converter, whose result
// is then taken; leading zeros are skipped up to the first digit kept, and then
// one sprite word is sent per digit, waiting out any stalls on the output.
// The converter handles one bit per cycle.
// s_tready stays low from the draw until the last sprite is loaded into the
// output register. When the receiver holds m_tready low the output word holds
// and the sequencer waits. Synchronous reset clears the score, the registers
// and all control state; no output is valid after reset.
module score_to_digit_sprites
    import stod_pkg::*;
#(
    parameter int VALUE_BITS = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // Input word: action [1:0], new_value [17:2], delta [33:18], zero pad
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [39:0]          s_tdata,
    // Output word: sprite_x [7:0], sprite_y [15:8], tile [23:16]
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [23:0]          m_tdata,
    output logic                 m_tlast,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_addr,
    input  logic [CFG_W-1:0]     cfg_wdata
);

    localparam int DIGITS = ((VALUE_BITS * 1233) >> 12) + 1;
    localparam int IDX_W  = $clog2(DIGITS);
    localparam int BCD_W  = DIGITS * DIGIT_W;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_SKIP,
        ST_EMIT
    } state_t;

    state_t                state_reg;
    logic [VALUE_BITS-1:0] score_reg;
    logic [COORD_W-1:0]    x_origin_reg;
    logic [COORD_W-1:0]    y_origin_reg;
    logic [COORD_W-1:0]    first_tile_reg;
    logic [IDX_W-1:0]      idx_reg;
    logic [COORD_W-1:0]    x_reg;
    logic                  m_tvalid_reg;
    logic                  m_tlast_reg;
    logic [23:0]           m_tdata_reg;

    action_t               action;
    logic [IN_W-1:0]       new_value;
    logic [IN_W-1:0]       delta;
    logic [VALUE_BITS+IN_W-1:0] value_ext;
    logic [VALUE_BITS+IN_W-1:0] delta_ext;
    logic                  accept;
    logic                  conv_start;
    logic                  conv_done;
    logic [BCD_W-1:0]      bcd;
    logic [DIGIT_W-1:0]    digit;
    logic                  slot_free;

    assign action    = action_t'(s_tdata[1:0]);
    assign new_value = s_tdata[17:2];
    assign delta     = s_tdata[33:18];
    assign value_ext = {{VALUE_BITS{1'b0}}, new_value};
    assign delta_ext = {{VALUE_BITS{delta[IN_W-1]}}, delta};

    assign s_tready   = (state_reg == ST_IDLE);
    assign accept     = s_tvalid && s_tready;
    assign conv_start = accept && (action == ACT_DRAW);
    assign digit      = bcd[{idx_reg, 2'b00} +: DIGIT_W];
    assign slot_free  = !m_tvalid_reg || m_tready;

    stod_bcd_conv #(
        .VALUE_BITS (VALUE_BITS),
        .DIGITS     (DIGITS)
    ) u_conv (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (conv_start),
        .value   (score_reg),
        .done    (conv_done),
        .bcd     (bcd)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            score_reg      <= '0;
            x_origin_reg   <= '0;
            y_origin_reg   <= '0;
            first_tile_reg <= '0;
            m_tvalid_reg   <= 1'b0;
            idx_reg        <= '0;
        end else begin
            if (cfg_we) begin
                case (cfg_addr)
                    REG_X_ORIGIN:   x_origin_reg   <= cfg_wdata;
                    REG_Y_ORIGIN:   y_origin_reg   <= cfg_wdata;
                    REG_FIRST_TILE: first_tile_reg <= cfg_wdata;
                    default: ;
                endcase
            end
            if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        case (action)
                            ACT_SET:  score_reg <= value_ext[VALUE_BITS-1:0];
                            ACT_ADD:  score_reg <= score_reg + delta_ext[VALUE_BITS-1:0];
                            ACT_DRAW: state_reg <= ST_CONV;
                            default: ;
                        endcase
                    end
                end
                ST_CONV: begin
                    if (conv_done) begin
                        idx_reg   <= IDX_W'(DIGITS - 1);
                        state_reg <= ST_SKIP;
                    end
                end
                ST_SKIP: begin
                    // Drop leading zeros but always keep the units digit
                    if (digit == '0 && idx_reg != '0) begin
                        idx_reg <= idx_reg - IDX_W'(1);
                    end else begin
                        state_reg <= ST_EMIT;
                    end
                end
                ST_EMIT: begin
                    if (slot_free) begin
                        m_tvalid_reg <= 1'b1;
                        if (idx_reg == '0) begin
                            state_reg <= ST_IDLE;
                        end else begin
                            idx_reg <= idx_reg - IDX_W'(1);
                        end
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
        // Payload: position counter and output word
        if (state_reg == ST_CONV) begin
            x_reg <= x_origin_reg;
        end else if (state_reg == ST_EMIT && slot_free) begin
            x_reg       <= x_reg + COORD_W'(X_STEP);
            m_tdata_reg <= {first_tile_reg + {3'b000, digit, 1'b0}, y_origin_reg, x_reg};
            m_tlast_reg <= (idx_reg == '0);
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

`ifndef SYNTH
    a_draw_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tdata[1:0] == ACT_DRAW) |=> !s_tready)
        else $error("input taken while a draw is under way");

    a_mid_draw_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tlast) |-> !s_tready)
        else $error("input ready before the last sprite was loaded");

    a_done_in_conv: assert property (@(posedge aclk) disable iff (!aresetn)
        conv_done |-> (state_reg == ST_CONV))
        else $error("converter finished outside a draw");
`endif

endmodule
